FILE: hw/rtl/etfm_pkg.sv
// Shared types, constants and the CRC-8 function of the ESC telemetry frame monitor.
`timescale 1ns / 1ps
`default_nettype none
package etfm_pkg;

	localparam int unsigned WIN_LEN      = 10;
	localparam int unsigned BYTE_W       = 8;
	localparam int unsigned CUTOFF_W     = 11;
	localparam int unsigned TEMP_W       = 7;
	localparam int unsigned ERPM_W       = 16;
	localparam int unsigned FAULT_W      = 2;
	localparam int unsigned COUNT_W      = 16;
	localparam int unsigned CFG_IDX_W    = 2;
	localparam int unsigned CFG_DATA_W   = 16;
	localparam int unsigned OUT_DATA_W   = 56;

	localparam logic [BYTE_W-1:0]   CRC_POLY      = 8'h07;
	localparam logic [BYTE_W-1:0]   TEMP_MIN      = 8'd2;
	localparam logic [BYTE_W-1:0]   TEMP_MAX      = 8'd99;
	localparam logic [BYTE_W-1:0]   VOLT_HI_LIMIT = 8'd8;
	localparam logic [BYTE_W-1:0]   FILL_BYTE     = 8'h01;
	localparam logic [CUTOFF_W-1:0] CUTOFF_RESET  = 11'd0;
	localparam logic [TEMP_W-1:0]   TEMP_RESET    = 7'd80;
	localparam logic [ERPM_W-1:0]   ERPM_RESET    = 16'd8000;
	localparam logic [COUNT_W-1:0]  COUNT_MAX     = 16'hFFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CUTOFF_VOLTAGE = 2'd0,
		CFG_TEMP_LIMIT     = 2'd1,
		CFG_ERPM_LIMIT     = 2'd2
	} cfg_index_t;

	typedef enum logic [FAULT_W-1:0] {
		FAULT_NONE      = 2'd0,
		FAULT_OVERTEMP  = 2'd1,
		FAULT_UNDERVOLT = 2'd2,
		FAULT_OVERSPEED = 2'd3
	} fault_t;

	typedef logic [BYTE_W-1:0] byte_t;

	// One byte step of the MSB-first CRC-8, no reflection, no final xor.
	function automatic byte_t crc8_step(input byte_t crc_in, input byte_t data);
		byte_t c;
		c = crc_in ^ data;
		for (int b = 0; b < 8; b++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/esc_telemetry_frame_monitor_unit.sv
// Top level of the ESC telemetry frame monitor: byte window, frame check and result register.
`timescale 1ns / 1ps
`default_nettype none
// A result appears on the master side in the cycle after the byte that completes a frame.
// One byte transaction per cycle unless a held result stalls it. The window, the parallel CRC-8
// over nine bytes and the limit compares all settle between the window and result registers.
// Reset (arst_n, asynchronous, active low) clears the window to zero, sets the first-frame
// flag, clears the overspeed counter, loads the register defaults and empties the output.
module esc_telemetry_frame_monitor_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// Configuration write port.
	input  wire logic                             cfg_we,
	input  wire logic [etfm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [etfm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	// Slave side: one received byte per transaction.
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  wire logic [7:0]                       s_axis_tdata,  // [7:0] rx_byte
	input  wire logic                             s_axis_tuser,  // [0] armed_now
	// Master side: one result per valid frame.
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// [6:0] temperature, [17:7] voltage, [33:18] erpm, [35:34] fault_code,
	// [36] disarm_request, [37] first_frame, [53:38] overspeed_total, [55:54] zero
	output logic [etfm_pkg::OUT_DATA_W-1:0]       m_axis_tdata
);
	import etfm_pkg::*;

	// Configuration registers.
	logic [CUTOFF_W-1:0] cutoff_voltage_q;
	logic [TEMP_W-1:0]   temp_limit_q;
	logic [ERPM_W-1:0]   erpm_limit_q;

	// Block state.
	byte_t               window_q [WIN_LEN];
	logic                awaiting_first_q;
	logic [COUNT_W-1:0]  overspeed_count_q;

	// Output register.
	logic                out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	// Combinational frame evaluation.
	byte_t               win_shift [WIN_LEN];
	byte_t               crc_calc;
	logic                frame_ok;
	logic                in_fire;
	logic [TEMP_W-1:0]   temp_val;
	logic [CUTOFF_W-1:0] volt_val;
	logic [ERPM_W-1:0]   erpm_val;
	fault_t              fault_val;
	logic                disarm_val;
	logic [COUNT_W-1:0]  count_next;

	// The output register frees up in the same cycle that its transaction completes,
	// so a new byte is taken whenever the result, if any, can move on.
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// The window as it stands once the incoming byte has been shifted in at the top.
	always_comb begin
		for (int i = 0; i < WIN_LEN - 1; i++) begin
			win_shift[i] = window_q[i+1];
		end
		win_shift[WIN_LEN-1] = s_axis_tdata;
	end

	// CRC-8 over the nine payload bytes; this collapses into one XOR network per bit.
	always_comb begin
		crc_calc = '0;
		for (int i = 0; i < WIN_LEN - 1; i++) begin
			crc_calc = crc8_step(crc_calc, win_shift[i]);
		end
	end

	always_comb begin
		frame_ok = (win_shift[0] >= TEMP_MIN) && (win_shift[0] <= TEMP_MAX)
			&& (win_shift[1] < VOLT_HI_LIMIT)
			&& (win_shift[3] == '0) && (win_shift[4] == '0)
			&& (win_shift[5] == '0) && (win_shift[6] == '0)
			&& (crc_calc == win_shift[WIN_LEN-1]);

		// Byte 0 is below 100 and byte 1 below 8 on a valid frame, so the
		// narrow fields lose nothing.
		temp_val = win_shift[0][TEMP_W-1:0];
		volt_val = {win_shift[1][CUTOFF_W-BYTE_W-1:0], win_shift[2]};
		erpm_val = {win_shift[7], win_shift[8]};

		// Faults are prioritised: temperature first, then voltage, then speed.
		if (temp_val > temp_limit_q) begin
			fault_val = FAULT_OVERTEMP;
		end else if (volt_val < cutoff_voltage_q) begin
			fault_val = FAULT_UNDERVOLT;
		end else if (erpm_val > erpm_limit_q) begin
			fault_val = FAULT_OVERSPEED;
		end else begin
			fault_val = FAULT_NONE;
		end

		disarm_val = (fault_val != FAULT_NONE) && s_axis_tuser;

		// The counter only counts when overspeed is the reported fault, and saturates.
		if (fault_val == FAULT_OVERSPEED && overspeed_count_q != COUNT_MAX) begin
			count_next = overspeed_count_q + COUNT_W'(1);
		end else begin
			count_next = overspeed_count_q;
		end
	end

	// Configuration writes; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_voltage_q <= CUTOFF_RESET;
			temp_limit_q     <= TEMP_RESET;
			erpm_limit_q     <= ERPM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CUTOFF_VOLTAGE: cutoff_voltage_q <= cfg_wdata[CUTOFF_W-1:0];
				CFG_TEMP_LIMIT:     temp_limit_q     <= cfg_wdata[TEMP_W-1:0];
				CFG_ERPM_LIMIT:     erpm_limit_q     <= cfg_wdata[ERPM_W-1:0];
				default: ;
			endcase
		end
	end

	// Window and frame state. After a valid frame the whole window is refilled with ones.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN_LEN; i++) begin
				window_q[i] <= '0;
			end
			awaiting_first_q  <= 1'b1;
			overspeed_count_q <= '0;
		end else if (in_fire) begin
			for (int i = 0; i < WIN_LEN; i++) begin
				window_q[i] <= frame_ok ? FILL_BYTE : win_shift[i];
			end
			if (frame_ok) begin
				awaiting_first_q  <= 1'b0;
				overspeed_count_q <= count_next;
			end
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			out_valid_q <= in_fire && frame_ok;
		end
	end

	// Output payload, loaded only when a frame result is captured.
	always_ff @(posedge clk) begin
		if (in_fire && frame_ok) begin
			out_data_q <= {2'b00, count_next, awaiting_first_q, disarm_val,
				fault_val, erpm_val, volt_val, temp_val};
		end
	end

	// A reported first frame means the flag has been cleared behind it.
	a_first_clears : assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[37]) |-> !awaiting_first_q)
		else $error("first_frame reported while the first-frame flag is still set");

	// A disarm request is only ever raised together with a fault.
	a_disarm_fault : assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[36]) |-> (m_axis_tdata[35:34] != FAULT_NONE))
		else $error("disarm_request without a fault");

	// An overspeed result always carries a nonzero running total.
	a_overspeed_total : assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[35:34] == FAULT_OVERSPEED)
		|-> (m_axis_tdata[53:38] != '0))
		else $error("overspeed fault reported with a zero total");

	// The saturating counter never moves backwards.
	a_count_monotonic : assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (overspeed_count_q >= $past(overspeed_count_q)))
		else $error("overspeed counter decreased");

	// A completed frame leaves the window refilled with ones.
	a_refill : assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && frame_ok) |=> (window_q[0] == FILL_BYTE && window_q[WIN_LEN-1] == FILL_BYTE))
		else $error("window not refilled after a valid frame");

endmodule
`default_nettype wire

FILE: sim/tb_esc_telemetry_frame_monitor_unit.sv
// Self-checking testbench of the ESC telemetry frame monitor unit with its scoreboard.
`timescale 1ns / 1ps
module tb_esc_telemetry_frame_monitor_unit;
	import etfm_pkg::*;

	// Some 550 byte transactions with idling on both sides, one long receiver hold and the
	// drains stay well within the limit, so it leaves a wide margin.
	localparam int unsigned CYCLE_LIMIT   = 40_000;
	// A result is registered in the cycle after the byte that completes its frame.
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned MAX_PRINTED   = 40;
	localparam int unsigned IDLE_PCT      = 29;
	// The write port has one index with no register behind it.
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

	typedef logic [WIN_LEN-1:0][BYTE_W-1:0] frame_bytes_t;

	// Scoreboard: keeps its own copy of the window, the counters and the limit registers, works
	// out the telemetry report that each accepted byte causes, and checks the reports that leave.
	class telemetry_scoreboard;
		typedef struct packed {
			logic [TEMP_W-1:0]   temperature;
			logic [CUTOFF_W-1:0] voltage;
			logic [ERPM_W-1:0]   erpm;
			fault_t              fault;
			logic                disarm;
			logic                first;
			logic [COUNT_W-1:0]  overspeed_total;
		} report_t;

		logic [WIN_LEN-1:0][BYTE_W-1:0] window;
		logic                           awaiting_first;
		logic [COUNT_W-1:0]             overspeed_count;
		logic [CUTOFF_W-1:0]            cutoff_voltage;
		logic [TEMP_W-1:0]              temp_limit;
		logic [ERPM_W-1:0]              erpm_limit;
		report_t                        pending_reports[$];
		int unsigned                    errors;

		function new();
			window          = '0;
			awaiting_first  = 1'b1;
			overspeed_count = '0;
			cutoff_voltage  = CUTOFF_RESET;
			temp_limit      = TEMP_RESET;
			erpm_limit      = ERPM_RESET;
			errors          = 0;
		endfunction

		// Bit-serial form of the CRC-8, fed one message bit at a time, most significant first.
		function logic [BYTE_W-1:0] crc_of(input logic [WIN_LEN-2:0][BYTE_W-1:0] bytes);
			logic [BYTE_W-1:0] crc;
			logic              feedback;
			crc = '0;
			for (int i = 0; i < WIN_LEN - 1; i++) begin
				for (int k = BYTE_W - 1; k >= 0; k--) begin
					feedback = crc[BYTE_W-1] ^ bytes[i][k];
					crc = {crc[BYTE_W-2:0], 1'b0} ^ (feedback ? CRC_POLY : 8'h00);
				end
			end
			return crc;
		endfunction

		function void write_reg(input logic [CFG_IDX_W-1:0] idx,
		                        input logic [CFG_DATA_W-1:0] value);
			case (idx)
				CFG_CUTOFF_VOLTAGE: cutoff_voltage = value[CUTOFF_W-1:0];
				CFG_TEMP_LIMIT:     temp_limit     = value[TEMP_W-1:0];
				CFG_ERPM_LIMIT:     erpm_limit     = value[ERPM_W-1:0];
				default:            ;
			endcase
		endfunction

		function int unsigned outstanding();
			return pending_reports.size();
		endfunction

		// Shifts one accepted byte in; the CRC is only worked out once the cheap tests pass.
		function void take_byte(input byte_t rx, input logic armed);
			report_t r;
			window = {rx, window[WIN_LEN-1:1]};
			if (window[0] < TEMP_MIN || window[0] > TEMP_MAX || window[1] >= VOLT_HI_LIMIT
			    || window[6:3] != '0 || crc_of(window[WIN_LEN-2:0]) != window[WIN_LEN-1])
				return;
			r.temperature = window[0][TEMP_W-1:0];
			r.voltage     = {window[1][2:0], window[2]};
			r.erpm        = {window[7], window[8]};
			if (r.temperature > temp_limit) begin
				r.fault = FAULT_OVERTEMP;
			end else if (r.voltage < cutoff_voltage) begin
				r.fault = FAULT_UNDERVOLT;
			end else if (r.erpm > erpm_limit) begin
				r.fault = FAULT_OVERSPEED;
				if (overspeed_count != COUNT_MAX)
					overspeed_count++;
			end else begin
				r.fault = FAULT_NONE;
			end
			r.disarm          = (r.fault != FAULT_NONE) && armed;
			r.first           = awaiting_first;
			awaiting_first    = 1'b0;
			r.overspeed_total = overspeed_count;
			window            = {WIN_LEN{FILL_BYTE}};
			pending_reports.push_back(r);
		endfunction

		task report(input string msg);
			errors++;
			if (errors <= MAX_PRINTED)
				$display("[%0t] mismatch: %s", $realtime, msg);
		endtask

		task compare_field(input string name, input logic [15:0] got, input logic [15:0] want);
			if (got !== want)
				report($sformatf("%s is %0h, expected %0h", name, got, want));
		endtask

		task check_report(input logic [OUT_DATA_W-1:0] d);
			report_t want;
			if (pending_reports.size() == 0) begin
				report($sformatf("report %h arrived with none expected", d));
				return;
			end
			want = pending_reports.pop_front();
			compare_field("temperature", 16'(d[6:0]), 16'(want.temperature));
			compare_field("voltage", 16'(d[17:7]), 16'(want.voltage));
			compare_field("erpm", d[33:18], want.erpm);
			compare_field("fault_code", 16'(d[35:34]), 16'(want.fault));
			compare_field("disarm_request", 16'(d[36]), 16'(want.disarm));
			compare_field("first_frame", 16'(d[37]), 16'(want.first));
			compare_field("overspeed_total", d[53:38], want.overspeed_total);
			compare_field("padding", 16'(d[55:54]), 16'h0000);
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata;
	logic                  s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	telemetry_scoreboard sb = new();

	int unsigned tx_idle_pct    = IDLE_PCT;
	int unsigned rx_idle_pct    = IDLE_PCT;
	int unsigned rx_hold_cycles = 0;
	int unsigned cycle_count    = 0;

	always #4 clk = ~clk;

	esc_telemetry_frame_monitor_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// Every process samples at the rising edge, before any nonblocking update of that edge
	// lands, so each one sees the values that the block itself saw.

	// Input monitor: every accepted byte transaction goes to the scoreboard.
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			sb.take_byte(s_axis_tdata, s_axis_tuser);
	end

	// Receiver: checks each accepted report and drives tready. A hold request keeps tready low
	// until its count runs out, so that the output register fills and the input stalls.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_report(m_axis_tdata);
		if (rx_hold_cycles > 0) begin
			rx_hold_cycles = rx_hold_cycles - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Fills in the CRC byte over the first nine bytes.
	function automatic frame_bytes_t seal(input frame_bytes_t f);
		f[WIN_LEN-1] = sb.crc_of(f[WIN_LEN-2:0]);
		return f;
	endfunction

	// The voltage goes in as sixteen bits so that an oversized high byte can be built too.
	function automatic frame_bytes_t make_frame(input byte_t b0, input logic [15:0] volt,
	                                            input logic [15:0] erpm);
		frame_bytes_t f;
		f    = '0;
		f[0] = b0;
		f[1] = volt[15:8];
		f[2] = volt[7:0];
		f[7] = erpm[15:8];
		f[8] = erpm[7:0];
		return seal(f);
	endfunction

	function automatic int clamp(input int v, input int lo, input int hi);
		return (v < lo) ? lo : (v > hi) ? hi : v;
	endfunction

	// A well-formed frame; half of the time each value sits within three of its limit so that the
	// strict and non-strict compares are both exercised.
	function automatic frame_bytes_t random_frame();
		int temp, volt, erpm;
		temp = $urandom_range(1) ? int'($urandom_range(TEMP_MAX, TEMP_MIN))
		     : clamp(int'(sb.temp_limit) + int'($urandom_range(4)) - 2,
		             int'(TEMP_MIN), int'(TEMP_MAX));
		volt = $urandom_range(1) ? int'($urandom_range(2047))
		     : clamp(int'(sb.cutoff_voltage) + int'($urandom_range(6)) - 3, 0, 2047);
		erpm = $urandom_range(1) ? int'($urandom_range(65535))
		     : clamp(int'(sb.erpm_limit) + int'($urandom_range(6)) - 3, 0, 65535);
		return make_frame(byte_t'(temp), 16'(volt), 16'(erpm));
	endfunction

	// A frame that misses exactly one of the validity rules.
	function automatic frame_bytes_t broken_frame();
		frame_bytes_t f;
		int unsigned  flaw;
		f    = random_frame();
		flaw = $urandom_range(3);
		if (flaw == 0) begin
			f[WIN_LEN-1] = f[WIN_LEN-1] ^ (8'h01 << $urandom_range(7));
		end else if (flaw == 1) begin
			f[0] = $urandom_range(1) ? byte_t'($urandom_range(1)) : byte_t'($urandom_range(255, 100));
			f = seal(f);
		end else if (flaw == 2) begin
			f[1] = byte_t'($urandom_range(255, VOLT_HI_LIMIT));
			f = seal(f);
		end else begin
			f[$urandom_range(6, 3)] = byte_t'($urandom_range(255, 1));
			f = seal(f);
		end
		return f;
	endfunction

	// Offers one byte. tvalid stays high after an accepted transaction unless the next call
	// idles or the caller drains, so each signal gets at most one update per edge.
	task automatic send_byte(input byte_t value, input logic armed);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= value;
		s_axis_tuser  <= armed;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	// Only the armed flag of the closing byte matters; the others are random.
	task automatic send_frame(input frame_bytes_t f, input logic armed);
		for (int i = 0; i < WIN_LEN - 1; i++)
			send_byte(f[i], 1'($urandom_range(1)));
		send_byte(f[WIN_LEN-1], armed);
	endtask

	// Stops offering and waits until every expected report has left, then lets the block settle.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		sb.write_reg(idx, value);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [CFG_DATA_W-1:0] cutoff, input logic [CFG_DATA_W-1:0] temp,
	                         input logic [CFG_DATA_W-1:0] erpm);
		cfg_write(CFG_CUTOFF_VOLTAGE, cutoff);
		cfg_write(CFG_TEMP_LIMIT, temp);
		cfg_write(CFG_ERPM_LIMIT, erpm);
	endtask

	// Mostly well-formed frames with random content, the rest near misses and bursts of noise.
	task automatic run_random(input int unsigned n_bytes);
		int unsigned sent, pick, burst;
		sent = 0;
		while (sent < n_bytes) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				send_frame(random_frame(), 1'($urandom_range(1)));
				sent += WIN_LEN;
			end else if (pick < 88) begin
				send_frame(broken_frame(), 1'($urandom_range(1)));
				sent += WIN_LEN;
			end else begin
				burst = $urandom_range(8, 1);
				repeat (burst) send_byte(byte_t'($urandom), 1'($urandom_range(1)));
				sent += burst;
			end
		end
	endtask

	initial begin
		frame_bytes_t f;
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= CFG_CUTOFF_VOLTAGE;
		cfg_wdata     <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= 1'b0;
		m_axis_tready <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed frames under the reset limits: the first frame at the lowest temperature,
		// overtemperature armed and disarmed, values sitting exactly on the limits, and
		// overspeed with the drive disarmed and at the extremes of voltage and ERPM.
		send_frame(make_frame(TEMP_MIN, 16'd0, 16'd0), 1'b1);
		send_frame(make_frame(TEMP_MAX, 16'd2047, 16'd100), 1'b1);
		send_frame(make_frame(8'd81, 16'd5, 16'd0), 1'b0);
		send_frame(make_frame(8'd80, 16'd1000, 16'd8000), 1'b1);
		send_frame(make_frame(8'd40, 16'd1000, 16'd8001), 1'b0);
		send_frame(make_frame(8'd40, 16'd2047, 16'hFFFF), 1'b1);
		// Near misses, none of which may give a report: temperature byte just below and
		// just above its range, voltage high byte too large, a bad CRC, a nonzero reserved byte.
		send_frame(make_frame(8'd1, 16'd100, 16'd100), 1'b1);
		send_frame(make_frame(8'd100, 16'd100, 16'd100), 1'b1);
		send_frame(make_frame(8'd50, 16'h0800, 16'd0), 1'b1);
		f = make_frame(8'd50, 16'd300, 16'd300);
		f[WIN_LEN-1] = f[WIN_LEN-1] ^ 8'h01;
		send_frame(f, 1'b1);
		f = make_frame(8'd50, 16'd300, 16'd300);
		f[5] = 8'hFF;
		send_frame(seal(f), 1'b1);
		drain();

		// An oversized cutoff keeps its low eleven bits; the spare index must change nothing.
		cfg_write(CFG_CUTOFF_VOLTAGE, 16'hFFFF);
		cfg_write(CFG_UNUSED_INDEX, 16'h0000);
		cfg_write(CFG_UNUSED_INDEX, 16'($urandom));
		send_frame(make_frame(8'd50, 16'd2046, 16'd0), 1'b1);
		send_frame(make_frame(8'd50, 16'd2047, 16'd9000), 1'b1);
		send_frame(make_frame(TEMP_MAX, 16'd0, 16'hFFFF), 1'b1);
		drain();
		// A temperature limit whose low seven bits are zero flags every frame as overtemperature.
		cfg_write(CFG_TEMP_LIMIT, 16'hFF80);
		cfg_write(CFG_ERPM_LIMIT, 16'hFFFF);
		send_frame(make_frame(TEMP_MIN, 16'd2047, 16'hFFFF), 1'b1);
		drain();

		// Random phases, each under its own limits.
		configure(16'd300, 16'd60, 16'd30000);
		run_random(90);
		drain();

		// A long stretch with no idling on either side, under limits that can never be exceeded.
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		configure(16'd0, 16'(TEMP_MAX), 16'hFFFF);
		run_random(80);
		tx_idle_pct = IDLE_PCT;
		rx_idle_pct = IDLE_PCT;

		// The receiver holds off while frames keep coming, so the block must stall its input;
		// afterwards the sender pauses until every report has left.
		rx_hold_cycles = 400;
		repeat (4) send_frame(random_frame(), 1'($urandom_range(1)));
		drain();

		configure(16'($urandom_range(2047)), 16'($urandom_range(TEMP_MAX)),
		          16'($urandom_range(65535)));
		run_random(80);
		drain();

		// Highest cutoff, an oversized temperature limit and a zero ERPM limit.
		configure(16'd2047, 16'hFFFF, 16'd0);
		run_random(80);
		drain();

		// Overspeed frames back to back at full rate under a zero ERPM limit.
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		configure(16'd0, 16'(TEMP_MAX), 16'd0);
		repeat (3)
			send_frame(make_frame(TEMP_MIN, 16'd0, 16'hFFFF), 1'b1);
		drain();

		if (sb.errors == 0 && sb.outstanding() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
